### rtl/sbeq_pkg.sv
// Shared types, constants, microcode program and saturation helpers of the three band equalizer.
`timescale 1ns / 1ps
`default_nettype none

package sbeq_pkg;

   localparam int CHANNELS_DEF   = 2;
   localparam int COEF_FRAC_DEF  = 16;
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 20;
   localparam int WORD_BITS      = 40;
   localparam int LO_BITS        = 20;
   localparam int HI_BITS        = WORD_BITS - LO_BITS;
   localparam int NUM_REGS       = 6;
   localparam int NUM_BANDS      = 3;
   localparam int REG_BITS       = 60;
   localparam int CSR_IDX_W      = 3;
   localparam int STEP_W         = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOW_FF,
      REG_LOW_FB,
      REG_PEAK_FF,
      REG_PEAK_FB,
      REG_HIGH_FF,
      REG_HIGH_FB
   } reg_idx_type;

   typedef enum logic [1:0] {
      BAND_LOW,
      BAND_PEAK,
      BAND_HIGH
   } band_type;

   typedef enum logic [2:0] {
      COEF_B0,
      COEF_B1,
      COEF_B2,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_Y,
      WB_T1,
      WB_T2,
      WB_Z1,
      WB_Z2
   } wb_op_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_SWITCH,
      ACT_FINISH
   } act_type;

   typedef enum logic {
      JMP_NONE,
      JMP_SINGLE
   } jump_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef struct packed {
      logic              issue;
      coef_sel_type      coef;
      wb_op_type         op;
      band_type          band;
      logic              chan;
      act_type           act;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic         load_in;
      logic         clear;
      logic         issue;
      coef_sel_type coef;
      wb_op_type    op;
      band_type     band;
      logic         chan;
      logic         switch_ch;
      logic         finish;
   } dp_ctl_type;

   typedef struct packed {
      logic                          mode;
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic                          block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic                          block_end_out;
   } rsp_type;

   localparam logic [STEP_W-1:0] STEP_FINISH = 5'd31;

   function automatic logic signed [WORD_BITS-1:0] sat_to_word(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi[WORD_BITS-1:0];
      end else if (v < lo) begin
         return lo[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_to_sample(
      input logic signed [WORD_BITS-1:0] v);
      logic signed [WORD_BITS-1:0] hi;
      logic signed [WORD_BITS-1:0] lo;
      hi = (WORD_BITS'(1) <<< (SAMPLE_BITS - 1)) - WORD_BITS'(1);
      lo = -hi - WORD_BITS'(1);
      if (v > hi) begin
         return hi[SAMPLE_BITS-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // One multiply step of a band: the coefficient, and what its rounded product does.
   function automatic ucode_type mac_step(input coef_sel_type c, input wb_op_type o,
                                          input band_type b, input logic ch);
      ucode_type w;
      w.issue  = 1'b1;
      w.coef   = c;
      w.op     = o;
      w.band   = b;
      w.chan   = ch;
      w.act    = ACT_NONE;
      w.jump   = JMP_NONE;
      w.target = '0;
      return w;
   endfunction

   function automatic ucode_type ctl_step(input act_type a, input jump_type j,
                                          input logic [STEP_W-1:0] t);
      ucode_type w;
      w.issue  = 1'b0;
      w.coef   = COEF_B0;
      w.op     = WB_NONE;
      w.band   = BAND_LOW;
      w.chan   = 1'b0;
      w.act    = a;
      w.jump   = j;
      w.target = t;
      return w;
   endfunction

   // Program: five products per band (b0 gives y, b1 and b2 start the new delay
   // words, a1 and a2 finish them once y is back), three bands per channel.
   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         5'd0:  w = mac_step(COEF_B0, WB_Y,  BAND_LOW,  1'b0);
         5'd1:  w = mac_step(COEF_B1, WB_T1, BAND_LOW,  1'b0);
         5'd2:  w = mac_step(COEF_B2, WB_T2, BAND_LOW,  1'b0);
         5'd3:  w = mac_step(COEF_A1, WB_Z1, BAND_LOW,  1'b0);
         5'd4:  w = mac_step(COEF_A2, WB_Z2, BAND_LOW,  1'b0);
         5'd5:  w = mac_step(COEF_B0, WB_Y,  BAND_PEAK, 1'b0);
         5'd6:  w = mac_step(COEF_B1, WB_T1, BAND_PEAK, 1'b0);
         5'd7:  w = mac_step(COEF_B2, WB_T2, BAND_PEAK, 1'b0);
         5'd8:  w = mac_step(COEF_A1, WB_Z1, BAND_PEAK, 1'b0);
         5'd9:  w = mac_step(COEF_A2, WB_Z2, BAND_PEAK, 1'b0);
         5'd10: w = mac_step(COEF_B0, WB_Y,  BAND_HIGH, 1'b0);
         5'd11: w = mac_step(COEF_B1, WB_T1, BAND_HIGH, 1'b0);
         5'd12: w = mac_step(COEF_B2, WB_T2, BAND_HIGH, 1'b0);
         5'd13: w = mac_step(COEF_A1, WB_Z1, BAND_HIGH, 1'b0);
         5'd14: w = mac_step(COEF_A2, WB_Z2, BAND_HIGH, 1'b0);
         5'd15: w = ctl_step(ACT_SWITCH, JMP_SINGLE, STEP_FINISH);
         5'd16: w = mac_step(COEF_B0, WB_Y,  BAND_LOW,  1'b1);
         5'd17: w = mac_step(COEF_B1, WB_T1, BAND_LOW,  1'b1);
         5'd18: w = mac_step(COEF_B2, WB_T2, BAND_LOW,  1'b1);
         5'd19: w = mac_step(COEF_A1, WB_Z1, BAND_LOW,  1'b1);
         5'd20: w = mac_step(COEF_A2, WB_Z2, BAND_LOW,  1'b1);
         5'd21: w = mac_step(COEF_B0, WB_Y,  BAND_PEAK, 1'b1);
         5'd22: w = mac_step(COEF_B1, WB_T1, BAND_PEAK, 1'b1);
         5'd23: w = mac_step(COEF_B2, WB_T2, BAND_PEAK, 1'b1);
         5'd24: w = mac_step(COEF_A1, WB_Z1, BAND_PEAK, 1'b1);
         5'd25: w = mac_step(COEF_A2, WB_Z2, BAND_PEAK, 1'b1);
         5'd26: w = mac_step(COEF_B0, WB_Y,  BAND_HIGH, 1'b1);
         5'd27: w = mac_step(COEF_B1, WB_T1, BAND_HIGH, 1'b1);
         5'd28: w = mac_step(COEF_B2, WB_T2, BAND_HIGH, 1'b1);
         5'd29: w = mac_step(COEF_A1, WB_Z1, BAND_HIGH, 1'b1);
         5'd30: w = mac_step(COEF_A2, WB_Z2, BAND_HIGH, 1'b1);
         5'd31: w = ctl_step(ACT_FINISH, JMP_NONE, STEP_FINISH);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/sbeq_coef_regs.sv
// Coefficient register bank written through the plain configuration port.
`timescale 1ns / 1ps
`default_nettype none

module sbeq_coef_regs #(
   parameter int COEF_FRAC_BITS = sbeq_pkg::COEF_FRAC_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [sbeq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sbeq_pkg::REG_BITS-1:0]      csr_wdata,
   output logic      [sbeq_pkg::REG_BITS-1:0]      cfg [sbeq_pkg::NUM_REGS]
);

   logic [sbeq_pkg::REG_BITS-1:0] cfg_ff [sbeq_pkg::NUM_REGS];
   logic [sbeq_pkg::REG_BITS-1:0] cfg_in [sbeq_pkg::NUM_REGS];

   always_comb begin
      for (int i = 0; i < sbeq_pkg::NUM_REGS; i++) begin
         cfg_in[i] = cfg_ff[i];
         if (csr_we && (int'(csr_index) == i)) begin
            cfg_in[i] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sbeq_pkg::NUM_REGS; i++) begin
            // Feedforward registers start as a unity b0; feedback registers start at zero.
            if ((i == int'(sbeq_pkg::REG_LOW_FF)) || (i == int'(sbeq_pkg::REG_PEAK_FF)) ||
                (i == int'(sbeq_pkg::REG_HIGH_FF))) begin
               cfg_ff[i] <= sbeq_pkg::REG_BITS'(1) << COEF_FRAC_BITS;
            end else begin
               cfg_ff[i] <= '0;
            end
         end
      end else begin
         for (int i = 0; i < sbeq_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= cfg_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < sbeq_pkg::NUM_REGS; i++) begin
         cfg[i] = cfg_ff[i];
      end
   end

endmodule

`default_nettype wire

### rtl/sbeq_sequencer.sv
// Microcode sequencer: frame handshake, step counter and control word decode.
`timescale 1ns / 1ps
`default_nettype none

module sbeq_sequencer #(
   parameter int CHANNELS = sbeq_pkg::CHANNELS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_mode,
   input  wire logic                 out_free,
   output logic                      req_ready,
   output sbeq_pkg::dp_ctl_type      ctl
);

   localparam bit SINGLE = (CHANNELS == 1);

   sbeq_pkg::seq_state_type          state_ff;
   sbeq_pkg::seq_state_type          state_in;
   logic [sbeq_pkg::STEP_W-1:0]      step_ff;
   logic [sbeq_pkg::STEP_W-1:0]      step_in;
   sbeq_pkg::ucode_type              word;
   logic                             accept;

   assign word      = sbeq_pkg::ucode(step_ff);
   assign req_ready = (state_ff == sbeq_pkg::SEQ_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         sbeq_pkg::SEQ_IDLE: begin
            if (accept && !req_mode) begin
               state_in = sbeq_pkg::SEQ_RUN;
               step_in  = '0;
            end
         end
         sbeq_pkg::SEQ_RUN: begin
            // The last step holds until the output register can take the beat.
            if (word.act == sbeq_pkg::ACT_FINISH) begin
               if (out_free) begin
                  state_in = sbeq_pkg::SEQ_IDLE;
               end
            end else if ((word.jump == sbeq_pkg::JMP_SINGLE) && SINGLE) begin
               step_in = word.target;
            end else begin
               step_in = step_ff + sbeq_pkg::STEP_W'(1);
            end
         end
         default: begin
            state_in = sbeq_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.load_in   = accept && !req_mode;
      ctl.clear     = accept && req_mode;
      ctl.issue     = 1'b0;
      ctl.coef      = word.coef;
      ctl.op        = word.op;
      ctl.band      = word.band;
      ctl.chan      = word.chan;
      ctl.switch_ch = 1'b0;
      ctl.finish    = 1'b0;
      if (state_ff == sbeq_pkg::SEQ_RUN) begin
         ctl.issue     = word.issue;
         ctl.switch_ch = (word.act == sbeq_pkg::ACT_SWITCH);
         ctl.finish    = (word.act == sbeq_pkg::ACT_FINISH) && out_free;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbeq_pkg::SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

### rtl/sbeq_datapath.sv
// Shared multiply pipeline, band registers, delay word store and result register.
`timescale 1ns / 1ps
`default_nettype none

module sbeq_datapath #(
   parameter int CHANNELS       = sbeq_pkg::CHANNELS_DEF,
   parameter int COEF_FRAC_BITS = sbeq_pkg::COEF_FRAC_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sbeq_pkg::dp_ctl_type           ctl,
   input  wire sbeq_pkg::req_type              req,
   input  wire logic [sbeq_pkg::REG_BITS-1:0]  cfg [sbeq_pkg::NUM_REGS],
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output sbeq_pkg::rsp_type                   rsp,
   output logic                                out_free
);

   localparam int USED_CH = (CHANNELS > 2) ? 2 : CHANNELS;
   localparam bit SINGLE  = (USED_CH == 1);
   localparam int DEPTH   = 2 * sbeq_pkg::NUM_BANDS * USED_CH;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int WB      = sbeq_pkg::WORD_BITS;
   localparam int CB      = sbeq_pkg::COEF_BITS;
   localparam int LB      = sbeq_pkg::LO_BITS;
   localparam int MUL_W   = CB + WB;
   localparam int PP_LO_W = CB + LB + 1;
   localparam int PP_HI_W = CB + sbeq_pkg::HI_BITS;
   localparam int RND_W   = MUL_W - COEF_FRAC_BITS;
   localparam int ACC_W   = RND_W + 2;
   localparam logic signed [MUL_W-1:0] RND = MUL_W'(1) <<< (COEF_FRAC_BITS - 1);

   typedef struct packed {
      sbeq_pkg::wb_op_type op;
      sbeq_pkg::band_type  band;
      logic                chan;
   } tag_type;

   function automatic logic [IDX_W-1:0] dl_index(input tag_type t, input logic second);
      int i;
      i = ((int'(t.chan) * sbeq_pkg::NUM_BANDS) + int'(t.band)) * 2 + int'(second);
      return IDX_W'(i);
   endfunction

   // Multiply stage and rounding stage, with the control that rides along.
   logic signed [PP_LO_W-1:0]           pp_lo_ff, pp_lo_in;
   logic signed [PP_HI_W-1:0]           pp_hi_ff, pp_hi_in;
   logic signed [RND_W-1:0]             prod_ff, prod_in;
   tag_type                             tag1_ff, tag1_in;
   tag_type                             tag2_ff;

   logic signed [WB-1:0]                x_ff, x_in;
   logic signed [ACC_W-1:0]             t1_ff, t1_in;
   logic signed [ACC_W-1:0]             t2_ff, t2_in;
   logic signed [sbeq_pkg::SAMPLE_BITS-1:0] right_ff, right_in;
   logic                                be_ff, be_in;
   logic signed [sbeq_pkg::SAMPLE_BITS-1:0] out_left_ff, out_left_in;
   sbeq_pkg::rsp_type                   rsp_data_ff, rsp_data_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic signed [WB-1:0]                z_ff [DEPTH];
   logic signed [WB-1:0]                z_in [DEPTH];

   logic [sbeq_pkg::REG_BITS-1:0]       ff_reg;
   logic [sbeq_pkg::REG_BITS-1:0]       fb_reg;
   logic signed [CB-1:0]                coef;
   logic signed [MUL_W-1:0]             full;
   logic signed [WB-1:0]                z_rd;
   logic signed [ACC_W-1:0]             zsum;
   logic signed [ACC_W-1:0]             diff;

   // Even register of a band holds b0..b2, the odd one a1 and a2.
   assign ff_reg = cfg[{ctl.band, 1'b0}];
   assign fb_reg = cfg[{ctl.band, 1'b1}];

   always_comb begin
      unique case (ctl.coef)
         sbeq_pkg::COEF_B0: coef = ff_reg[CB-1:0];
         sbeq_pkg::COEF_B1: coef = ff_reg[2*CB-1:CB];
         sbeq_pkg::COEF_B2: coef = ff_reg[3*CB-1:2*CB];
         sbeq_pkg::COEF_A1: coef = fb_reg[CB-1:0];
         sbeq_pkg::COEF_A2: coef = fb_reg[2*CB-1:CB];
         default:           coef = '0;
      endcase
   end

   // The 40-bit operand is split into an unsigned low half and a signed high half.
   assign pp_lo_in = PP_LO_W'(coef) * PP_LO_W'($signed({1'b0, x_ff[LB-1:0]}));
   assign pp_hi_in = PP_HI_W'(coef) * PP_HI_W'($signed(x_ff[WB-1:LB]));

   always_comb begin
      tag1_in.op   = ctl.issue ? ctl.op : sbeq_pkg::WB_NONE;
      tag1_in.band = ctl.band;
      tag1_in.chan = ctl.chan;
   end

   assign full    = (MUL_W'(pp_hi_ff) <<< LB) + MUL_W'(pp_lo_ff) + RND;
   assign prod_in = RND_W'(full >>> COEF_FRAC_BITS);

   // z1 is read when y is formed, z2 when the new z1 is started.
   assign z_rd = z_ff[dl_index(tag2_ff, tag2_ff.op == sbeq_pkg::WB_T1)];
   assign zsum = ACC_W'(prod_ff) + ACC_W'(z_rd);
   assign diff = ((tag2_ff.op == sbeq_pkg::WB_Z1) ? t1_ff : t2_ff) - ACC_W'(prod_ff);

   always_comb begin
      x_in        = x_ff;
      right_in    = right_ff;
      be_in       = be_ff;
      out_left_in = out_left_ff;
      t1_in       = t1_ff;
      t2_in       = t2_ff;
      priority if (ctl.load_in) begin
         x_in     = WB'(req.left_in);
         right_in = req.right_in;
         be_in    = req.block_end;
      end else if (ctl.switch_ch) begin
         x_in        = WB'(right_ff);
         out_left_in = sbeq_pkg::sat_to_sample(x_ff);
      end else if (tag2_ff.op == sbeq_pkg::WB_Y) begin
         x_in = sbeq_pkg::sat_to_word(64'(zsum));
      end
      if (tag2_ff.op == sbeq_pkg::WB_T1) begin
         t1_in = zsum;
      end
      if (tag2_ff.op == sbeq_pkg::WB_T2) begin
         t2_in = ACC_W'(prod_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         z_in[i] = z_ff[i];
      end
      // A clear frame wins over a delay write still draining from the frame before.
      if (ctl.clear) begin
         for (int i = 0; i < DEPTH; i++) begin
            z_in[i] = '0;
         end
      end else if ((tag2_ff.op == sbeq_pkg::WB_Z1) || (tag2_ff.op == sbeq_pkg::WB_Z2)) begin
         z_in[dl_index(tag2_ff, tag2_ff.op == sbeq_pkg::WB_Z2)] =
            sbeq_pkg::sat_to_word(64'(diff));
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish) begin
         rsp_data_in.left_out      = SINGLE ? out_left_ff : out_left_ff;
         rsp_data_in.right_out     = SINGLE ? '0 : sbeq_pkg::sat_to_sample(x_ff);
         rsp_data_in.block_end_out = be_ff;
         rsp_valid_in              = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.op   <= sbeq_pkg::WB_NONE;
         tag1_ff.band <= sbeq_pkg::BAND_LOW;
         tag1_ff.chan <= 1'b0;
         tag2_ff.op   <= sbeq_pkg::WB_NONE;
         tag2_ff.band <= sbeq_pkg::BAND_LOW;
         tag2_ff.chan <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DEPTH; i++) begin
            z_ff[i] <= '0;
         end
      end else begin
         tag1_ff      <= tag1_in;
         tag2_ff      <= tag1_ff;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < DEPTH; i++) begin
            z_ff[i] <= z_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pp_lo_ff    <= pp_lo_in;
      pp_hi_ff    <= pp_hi_in;
      prod_ff     <= prod_in;
      x_ff        <= x_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      right_ff    <= right_in;
      be_ff       <= be_in;
      out_left_ff <= out_left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_data_ff;

   // A band output must never land on top of a new sample being loaded.
   a_y_no_load: assert property (@(posedge clock) disable iff (reset)
      (tag2_ff.op == sbeq_pkg::WB_Y) |-> !(ctl.load_in || ctl.switch_ch))
      else $error("band output write collides with a sample load");

   // The new z1 is finished only after the partial sum of the same band.
   a_z1_after_t1: assert property (@(posedge clock) disable iff (reset)
      (tag2_ff.op == sbeq_pkg::WB_Z1) |->
         (($past(tag2_ff.op, 2) == sbeq_pkg::WB_T1) && ($past(tag2_ff.band, 2) == tag2_ff.band)))
      else $error("z1 write without a matching partial sum");

   a_z2_after_t2: assert property (@(posedge clock) disable iff (reset)
      (tag2_ff.op == sbeq_pkg::WB_Z2) |->
         (($past(tag2_ff.op, 2) == sbeq_pkg::WB_T2) && ($past(tag2_ff.band, 2) == tag2_ff.band)))
      else $error("z2 write without a matching partial sum");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over a beat not yet taken");

endmodule

`default_nettype wire

### rtl/stereo_three_band_biquad_eq_core.sv
// Top level of the stereo three band biquad equalizer.
`timescale 1ns / 1ps
`default_nettype none

// Each channel of a frame runs through a low shelf, a peaking and a high shelf
// biquad in transposed direct form II, with 40-bit delay words and a 24-bit
// saturated result. The sequencer runs one microcode step per cycle: five
// coefficient products per band per channel, issued through the single shared
// multiply pipeline, then a channel switch step and a finish step. The finish
// step waits while the output register still holds a beat that has not been
// taken. The sequencer then returns to idle, where it can accept the next beat,
// so a new frame is taken only once the frame before it has finished.
// A new frame is accepted as soon as the previous result sits in the output
// register, even if it has not been taken.
// A clear frame (mode 1) zeroes all delay words in its acceptance cycle and gives
// no result. Coefficient writes are meant for idle periods.
module stereo_three_band_biquad_eq_core #(
   parameter int CHANNELS       = sbeq_pkg::CHANNELS_DEF,
   parameter int COEF_FRAC_BITS = sbeq_pkg::COEF_FRAC_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire sbeq_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output sbeq_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [sbeq_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sbeq_pkg::REG_BITS-1:0]  csr_wdata
);

   logic [sbeq_pkg::REG_BITS-1:0] cfg [sbeq_pkg::NUM_REGS];
   sbeq_pkg::dp_ctl_type          ctl;
   logic                          out_free;

   sbeq_coef_regs #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_coef_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sbeq_sequencer #(
      .CHANNELS (CHANNELS)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   sbeq_datapath #(
      .CHANNELS       (CHANNELS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req       (req_data),
      .cfg       (cfg),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data),
      .out_free  (out_free)
   );

endmodule

`default_nettype wire
